// ===== rtl/core/iqs_pkg.sv =====
// Package for the iterative quicksort engine: sizes, command and status types.
// No dependencies; used by iqs_datapath, iqs_ctrl and the top level.
`default_nettype none
package iqs_pkg;

	localparam int MAX_ELEMS  = 64;
	localparam int VALUE_BITS = 32;
	localparam int IDX_W      = $clog2(MAX_ELEMS);
	localparam int CNT_W      = IDX_W + 1;
	localparam int STK_W      = 2 * IDX_W;

	typedef struct packed {
		logic load;
		logic push_root;
		logic pop;
		logic seg;
		logic pivot;
		logic rscan;
		logic lscan;
		logic finish;
		logic push2;
		logic emit_rd;
		logic emit_ld;
	} iqs_cmd_t;

	typedef struct packed {
		logic in_last;
		logic cnt_lt2;
		logic top_zero;
		logic piv_eq_right;
		logic piv_eq_left;
		logic le_r;
		logic le_l;
		logic out_taken;
		logic out_last;
	} iqs_sts_t;

endpackage
`default_nettype wire

// ===== rtl/core/iqs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module iqs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ===== rtl/core/iqs_datapath.sv =====
// Datapath: element store, bounds stack, partition cursors, pivot compare, output register.
// Depends on iqs_pkg and iqs_ram.
`default_nettype none
module iqs_datapath (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire iqs_pkg::iqs_cmd_t                   cmd,
	output iqs_pkg::iqs_sts_t                        sts,
	input  wire logic                                s_tvalid,
	input  wire logic [iqs_pkg::VALUE_BITS-1:0]      s_tdata,
	input  wire logic                                s_tlast,
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	output logic      [iqs_pkg::VALUE_BITS-1:0]      m_tdata,
	output logic                                     m_tlast
);

	localparam int IW = iqs_pkg::IDX_W;
	localparam int CW = iqs_pkg::CNT_W;
	localparam int VW = iqs_pkg::VALUE_BITS;

	logic [CW-1:0] cnt_q, top_q;
	logic [IW-1:0] k_q, lo_q, hi_q, piv_q, left_q, right_q;
	logic [VW-1:0] pv_q, out_data_q;
	logic          out_last_q, out_valid_q;

	logic                     st_we, sk_we;
	logic [IW-1:0]            st_waddr, st_raddr, sk_waddr, sk_raddr;
	logic [VW-1:0]            st_wdata, st_rdata;
	logic [iqs_pkg::STK_W-1:0] sk_wdata, sk_rdata;

	logic          cnt_full, cnt_lt2, top_zero, store_in;
	logic          eq_r, eq_l, le_r, le_l, push_lo_ok, push_hi_ok;
	logic [CW-1:0] cnt_m1, top_m1;

	assign cnt_full   = (cnt_q == CW'(iqs_pkg::MAX_ELEMS));
	assign cnt_lt2    = (cnt_q < CW'(2));
	assign top_zero   = (top_q == '0);
	assign cnt_m1     = cnt_q - CW'(1);
	assign top_m1     = top_q - CW'(1);
	assign store_in   = cmd.load && s_tvalid && !cnt_full;
	assign eq_r       = (piv_q == right_q);
	assign eq_l       = (piv_q == left_q);
	assign le_r       = ($signed(pv_q) <= $signed(st_rdata));
	assign le_l       = ($signed(st_rdata) <= $signed(pv_q));
	assign push_lo_ok = ({1'b0, lo_q} + CW'(1)) < {1'b0, piv_q};
	assign push_hi_ok = {1'b0, hi_q} > ({1'b0, piv_q} + CW'(1));

	always_comb begin
		st_we    = 1'b0;
		st_waddr = piv_q;
		st_wdata = pv_q;
		st_raddr = k_q;
		sk_we    = 1'b0;
		sk_waddr = top_q[IW-1:0];
		sk_wdata = {hi_q, lo_q};
		sk_raddr = top_m1[IW-1:0];
		if (store_in) begin
			st_we    = 1'b1;
			st_waddr = cnt_q[IW-1:0];
			st_wdata = s_tdata;
		end
		if (cmd.push_root && !cnt_lt2) begin
			sk_we    = 1'b1;
			sk_waddr = '0;
			sk_wdata = {cnt_m1[IW-1:0], {IW{1'b0}}};
		end
		if (cmd.seg) begin
			st_raddr = sk_rdata[IW-1:0];
		end
		if (cmd.pivot) begin
			st_raddr = right_q;
		end
		if (cmd.rscan && !eq_r) begin
			if (le_r) begin
				st_raddr = right_q - IW'(1);
			end else begin
				st_we    = 1'b1;
				st_wdata = st_rdata;
				st_raddr = left_q + IW'(1);
			end
		end
		if (cmd.lscan && !eq_l) begin
			if (le_l) begin
				st_raddr = left_q + IW'(1);
			end else begin
				st_we    = 1'b1;
				st_wdata = st_rdata;
				st_raddr = right_q - IW'(1);
			end
		end
		if (cmd.finish) begin
			st_we = 1'b1;
			if (push_lo_ok) begin
				sk_we    = 1'b1;
				sk_wdata = {piv_q - IW'(1), lo_q};
			end
		end
		if (cmd.push2 && push_hi_ok) begin
			sk_we    = 1'b1;
			sk_wdata = {hi_q, piv_q + IW'(1)};
		end
		if (cmd.emit_rd) begin
			st_raddr = k_q;
		end
	end

	iqs_ram #(.WIDTH(VW), .DEPTH(iqs_pkg::MAX_ELEMS)) u_store (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.raddr (st_raddr),
		.rdata (st_rdata)
	);

	iqs_ram #(.WIDTH(iqs_pkg::STK_W), .DEPTH(iqs_pkg::MAX_ELEMS)) u_stack (
		.clk   (clk),
		.we    (sk_we),
		.waddr (sk_waddr),
		.wdata (sk_wdata),
		.raddr (sk_raddr),
		.rdata (sk_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			top_q       <= '0;
			k_q         <= '0;
			lo_q        <= '0;
			hi_q        <= '0;
			piv_q       <= '0;
			left_q      <= '0;
			right_q     <= '0;
			out_last_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (store_in) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (cmd.push_root && !cnt_lt2) begin
				top_q <= CW'(1);
			end
			if (cmd.pop && !top_zero) begin
				top_q <= top_m1;
			end
			if (cmd.seg) begin
				lo_q    <= sk_rdata[IW-1:0];
				hi_q    <= sk_rdata[2*IW-1:IW];
				left_q  <= sk_rdata[IW-1:0];
				piv_q   <= sk_rdata[IW-1:0];
				right_q <= sk_rdata[2*IW-1:IW];
			end
			if (cmd.rscan && !eq_r) begin
				if (le_r) begin
					right_q <= right_q - IW'(1);
				end else begin
					piv_q  <= right_q;
					left_q <= left_q + IW'(1);
				end
			end
			if (cmd.lscan && !eq_l) begin
				if (le_l) begin
					left_q <= left_q + IW'(1);
				end else begin
					piv_q   <= left_q;
					right_q <= right_q - IW'(1);
				end
			end
			if (cmd.finish && push_lo_ok) begin
				top_q <= top_q + CW'(1);
			end
			if (cmd.push2 && push_hi_ok) begin
				top_q <= top_q + CW'(1);
			end
			if (cmd.emit_ld) begin
				out_last_q  <= (({1'b0, k_q} + CW'(1)) == cnt_q);
				out_valid_q <= 1'b1;
			end
			if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
				if (out_last_q) begin
					k_q   <= '0;
					cnt_q <= '0;
				end else begin
					k_q <= k_q + IW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pivot) begin
			pv_q <= st_rdata;
		end
		if (cmd.emit_ld) begin
			out_data_q <= st_rdata;
		end
	end

	always_comb begin
		sts.in_last      = s_tvalid && s_tlast;
		sts.cnt_lt2      = cnt_lt2;
		sts.top_zero     = top_zero;
		sts.piv_eq_right = eq_r;
		sts.piv_eq_left  = eq_l;
		sts.le_r         = le_r;
		sts.le_l         = le_l;
		sts.out_taken    = out_valid_q && m_tready;
		sts.out_last     = out_last_q;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

endmodule
`default_nettype wire

// ===== rtl/core/iqs_ctrl.sv =====
// Controller state machine: load, partition sequencing, stack pops and pushes, emit.
// Depends on iqs_pkg.
`default_nettype none
module iqs_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire iqs_pkg::iqs_sts_t sts,
	output iqs_pkg::iqs_cmd_t      cmd
);

	typedef enum logic [3:0] {
		LOAD, SORT_START, POP, SEG, PIVOT, RSCAN, LSCAN,
		FINISH, PUSH2, EMIT_RD, EMIT_LD, EMIT_WAIT
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= LOAD;
		end else begin
			case (state_q)
				LOAD: begin
					if (sts.in_last) state_q <= SORT_START;
				end
				SORT_START: begin
					state_q <= sts.cnt_lt2 ? EMIT_RD : POP;
				end
				POP: begin
					state_q <= sts.top_zero ? EMIT_RD : SEG;
				end
				SEG:    state_q <= PIVOT;
				PIVOT:  state_q <= RSCAN;
				RSCAN: begin
					if (sts.piv_eq_right) state_q <= FINISH;
					else if (!sts.le_r)   state_q <= LSCAN;
				end
				LSCAN: begin
					if (sts.piv_eq_left) state_q <= FINISH;
					else if (!sts.le_l)  state_q <= RSCAN;
				end
				FINISH:  state_q <= PUSH2;
				PUSH2:   state_q <= POP;
				EMIT_RD: state_q <= EMIT_LD;
				EMIT_LD: state_q <= EMIT_WAIT;
				EMIT_WAIT: begin
					if (sts.out_taken) state_q <= sts.out_last ? LOAD : EMIT_RD;
				end
				default: state_q <= LOAD;
			endcase
		end
	end

	always_comb begin
		cmd           = '0;
		cmd.load      = (state_q == LOAD);
		cmd.push_root = (state_q == SORT_START);
		cmd.pop       = (state_q == POP);
		cmd.seg       = (state_q == SEG);
		cmd.pivot     = (state_q == PIVOT);
		cmd.rscan     = (state_q == RSCAN);
		cmd.lscan     = (state_q == LSCAN);
		cmd.finish    = (state_q == FINISH);
		cmd.push2     = (state_q == PUSH2);
		cmd.emit_rd   = (state_q == EMIT_RD);
		cmd.emit_ld   = (state_q == EMIT_LD);
	end

endmodule
`default_nettype wire

// ===== rtl/core/iterative_quicksort_engine.sv =====
// Top level of the iterative quicksort engine: controller plus datapath.
// Depends on iqs_pkg, iqs_ctrl, iqs_datapath (and iqs_ram through it).
//
//   channel  dir  payload                                  request
//   s_*      in   tdata[31:0] value, tlast is_last         one element
//   m_*      out  tdata[31:0] sorted_value, tlast final    one sorted element
//
// Load takes one request per cycle into the element store (64 deep).
// Sort: each partition steps through pop, bounds read, pivot read, the scan steps, finish
// and second push; the scan steps compare against the single store read port.
// Emit: read, load and wait per result via the registered store read; m_tready stalls hold.
// Reset clears all control state; no clearing pass, store contents need none.
`default_nettype none
module iterative_quicksort_engine (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // [31:0] value
	input  wire logic        s_tlast,   // is_last
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [31:0] m_tdata,   // [31:0] sorted_value
	output logic             m_tlast    // final_flag
);

	iqs_pkg::iqs_cmd_t cmd;
	iqs_pkg::iqs_sts_t sts;

	iqs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	iqs_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.s_tvalid (s_tvalid),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	assign s_tready = cmd.load;

`ifndef NO_ASSERTIONS
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("load and emit overlap");

	a_last_stops_load: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> !s_tready)
		else $error("load continues after last request");

	a_final_reopens: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast |=> s_tready)
		else $error("load not reopened after final result");

	a_sort_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.pop, cmd.rscan, cmd.lscan, cmd.finish, cmd.push2}))
		else $error("conflicting sort commands");
`endif

endmodule
`default_nettype wire
